FILE: design/gnz_pkg.sv
// Shared types and constants for the 3-D gradient noise block.
// No dependencies.
package gnz_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int COORD_BITS_DEF = 32;

	typedef enum logic {
		OP_EVAL = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	// gradient selection by the low hash nibble
	localparam logic [3:0] GR_SPLIT_U = 4'd8;
	localparam logic [3:0] GR_SPLIT_V = 4'd4;
	localparam logic [3:0] GR_V_X0    = 4'd12;
	localparam logic [3:0] GR_V_X1    = 4'd14;

	// permutation table write, one per load transfer
	typedef struct packed {
		logic       en;
		logic [7:0] idx;
		logic [7:0] val;
	} perm_wr_t;

endpackage

FILE: design/gnz_perm_ram.sv
// One copy of the 256 x 8 permutation table, one write and two read ports.
// Depends on gnz_pkg.
module gnz_perm_ram
	import gnz_pkg::*;
(
	input  logic           clk,
	input  logic           en,
	input  perm_wr_t       wr,
	input  logic [7:0]     raddr_a,
	input  logic [7:0]     raddr_b,
	output logic [7:0]     rdata_a,
	output logic [7:0]     rdata_b
);

	logic [7:0] mem [256];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.val;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: design/gnz_hash.sv
// Three-level corner hash through seven table copies; loads follow the items
// so each copy sees writes and reads in order. Depends on gnz_pkg, gnz_perm_ram.
module gnz_hash
	import gnz_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  perm_wr_t   ld,
	input  logic [7:0] cell_x,
	input  logic [7:0] cell_y,
	input  logic [7:0] cell_z,
	output logic [7:0] hash [8]
);

	logic [7:0] cy_s1, cz_s1, cz_s2;
	perm_wr_t   wr_s1, wr_s2, wr1, wr2;
	logic [7:0] d0a, d0b, d1a, d1b, d2a, d2b;
	logic [7:0] a, b;
	logic [7:0] base [4];
	logic [7:0] ra [4];
	logic [7:0] rb [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= '0;
			wr_s2 <= '0;
		end else if (en) begin
			wr_s1 <= ld;
			wr_s2 <= wr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cy_s1 <= cell_y;
			cz_s1 <= cell_z;
			cz_s2 <= cz_s1;
		end
	end

	always_comb begin
		wr1    = wr_s1;
		wr1.en = wr_s1.en & en;
		wr2    = wr_s2;
		wr2.en = wr_s2.en & en;
	end

	gnz_perm_ram u_ram0 (
		.clk(clk), .en(en), .wr(ld),
		.raddr_a(cell_x), .raddr_b(cell_x + 8'd1),
		.rdata_a(d0a), .rdata_b(d0b)
	);

	assign a = d0a + cy_s1;
	assign b = d0b + cy_s1;

	gnz_perm_ram u_ram1 (
		.clk(clk), .en(en), .wr(wr1),
		.raddr_a(a), .raddr_b(a + 8'd1),
		.rdata_a(d1a), .rdata_b(d1b)
	);

	gnz_perm_ram u_ram2 (
		.clk(clk), .en(en), .wr(wr1),
		.raddr_a(b), .raddr_b(b + 8'd1),
		.rdata_a(d2a), .rdata_b(d2b)
	);

	// aa, ba, ab, bb
	assign base[0] = d1a + cz_s2;
	assign base[1] = d2a + cz_s2;
	assign base[2] = d1b + cz_s2;
	assign base[3] = d2b + cz_s2;

	for (genvar i = 0; i < 4; i++) begin : g_corner
		gnz_perm_ram u_ram (
			.clk(clk), .en(en), .wr(wr2),
			.raddr_a(base[i]), .raddr_b(base[i] + 8'd1),
			.rdata_a(ra[i]), .rdata_b(rb[i])
		);
		assign hash[i]     = ra[i];
		assign hash[i + 4] = rb[i];
	end

endmodule

FILE: design/gnz_fade.sv
// Quintic fade 6t^5 - 15t^4 + 10t^3, three register stages; two multiplies in the first, one in each of the others.
// Depends on gnz_pkg.
module gnz_fade
	import gnz_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] t,
	output logic [FRAC_BITS:0]   fade
);

	localparam int F = FRAC_BITS;
	localparam logic signed [F+4:0] FIFTEEN = (F+5)'(15) <<< F;
	localparam logic signed [F+4:0] TEN     = (F+5)'(10) <<< F;

	logic [F-1:0]          t_s2, t2_s2, t3_s3;
	logic signed [F+4:0]   m_s2;
	logic [F+3:0]          inner_s3;
	logic [F:0]            fade_s4;
	logic [F+2:0]          six_t;
	logic signed [F+4:0]   lin;
	logic [2*F-1:0]        sq, cube;
	logic signed [2*F+5:0] pm;
	logic signed [F+4:0]   inner;
	logic [2*F+3:0]        pf;

	assign six_t = {1'b0, t, 2'b00} + {2'b00, t, 1'b0};
	assign lin   = $signed({2'b00, six_t}) - FIFTEEN;
	assign sq    = t * t;
	assign pm    = $signed({1'b0, t}) * lin;
	assign cube  = t2_s2 * t_s2;
	assign inner = m_s2 + TEN;
	assign pf    = t3_s3 * inner_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2     <= t;
			t2_s2    <= sq[2*F-1:F];
			m_s2     <= pm[2*F+4:F];
			t3_s3    <= cube[2*F-1:F];
			inner_s3 <= inner[F+3:0];
			fade_s4  <= pf[2*F:F];
		end
	end

	assign fade = fade_s4;

endmodule

FILE: design/gnz_interp.sv
// Trilinear interpolation of eight corner gradients, six register stages
// (multiply, then add, per axis) and output saturation. Depends on gnz_pkg.
module gnz_interp
	import gnz_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [FRAC_BITS:0]          fu,
	input  logic [FRAC_BITS:0]          fv,
	input  logic [FRAC_BITS:0]          fw,
	input  logic signed [FRAC_BITS+2:0] grad [8],
	output logic signed [FRAC_BITS+1:0] noise
);

	localparam int F  = FRAC_BITS;
	localparam int LW = F + 5;
	localparam int PW = 2*F + 8;
	localparam logic signed [LW-1:0] OMAX = LW'((64'sd1 <<< (F+1)) - 1);
	localparam logic signed [LW-1:0] OMIN = -(LW'(64'sd1 <<< (F+1)));

	logic signed [PW-1:0] px_s5 [4];
	logic signed [LW-1:0] ax_s5 [4];
	logic signed [LW-1:0] lx_s6 [4];
	logic signed [PW-1:0] py_s7 [2];
	logic signed [LW-1:0] ay_s7 [2];
	logic signed [LW-1:0] ly_s8 [2];
	logic signed [PW-1:0] pz_s9;
	logic signed [LW-1:0] az_s9;
	logic signed [F+1:0]  r_s10;
	logic [F:0]           v_s5, v_s6, w_s5, w_s6, w_s7, w_s8;

	logic signed [LW:0]   dx [4];
	logic signed [LW:0]   dy [2];
	logic signed [LW:0]   dz;
	logic signed [LW-1:0] r;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dx[i] = (LW+1)'(grad[2*i+1]) - (LW+1)'(grad[2*i]);
		end
		for (int i = 0; i < 2; i++) begin
			dy[i] = (LW+1)'(lx_s6[2*i+1]) - (LW+1)'(lx_s6[2*i]);
		end
		dz = (LW+1)'(ly_s8[1]) - (LW+1)'(ly_s8[0]);
		r  = az_s9 + pz_s9[F+LW-1:F];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				px_s5[i] <= $signed({1'b0, fu}) * dx[i];
				ax_s5[i] <= LW'(grad[2*i]);
				lx_s6[i] <= ax_s5[i] + px_s5[i][F+LW-1:F];
			end
			for (int i = 0; i < 2; i++) begin
				py_s7[i] <= $signed({1'b0, v_s6}) * dy[i];
				ay_s7[i] <= lx_s6[2*i];
				ly_s8[i] <= ay_s7[i] + py_s7[i][F+LW-1:F];
			end
			pz_s9 <= $signed({1'b0, w_s8}) * dz;
			az_s9 <= ly_s8[0];
			if (r > OMAX) begin
				r_s10 <= OMAX[F+1:0];
			end else if (r < OMIN) begin
				r_s10 <= OMIN[F+1:0];
			end else begin
				r_s10 <= r[F+1:0];
			end
			v_s5 <= fv;
			v_s6 <= v_s5;
			w_s5 <= fw;
			w_s6 <= w_s5;
			w_s7 <= w_s6;
			w_s8 <= w_s7;
		end
	end

	assign noise = r_s10;

endmodule

FILE: design/gradient_noise_3d.sv
// 3-D improved gradient noise, fixed point, stream in and out.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a result waits on m_tready. Loads write the table, no result.
// Reset (arst_n, async low) clears the pipeline valid bits and the pending
// table writes in the hash; the table contents are undefined until loaded.
module gradient_noise_3d
	import gnz_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int IN_BITS   = 3*COORD_BITS + 16,
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS  = FRAC_BITS + 2,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// coord_x, coord_y, coord_z, table_index, table_value, zero pad
	input  logic [IN_W-1:0]  s_tdata,
	// operation
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// noise_value, zero pad
	output logic [OUT_W-1:0] m_tdata
);

	localparam int F    = FRAC_BITS;
	localparam int CB   = COORD_BITS;
	localparam int CX_W = (CB > F + 8) ? CB : F + 8;
	localparam int GW   = F + 3;
	localparam int NST  = 10;

	// Field unpacking
	logic signed [CB-1:0]   coord_x, coord_y, coord_z;
	logic [7:0]             table_index, table_value;
	op_t                    operation;
	logic signed [CX_W-1:0] ext_x, ext_y, ext_z;

	assign coord_x     = s_tdata[CB-1:0];
	assign coord_y     = s_tdata[2*CB-1:CB];
	assign coord_z     = s_tdata[3*CB-1:2*CB];
	assign table_index = s_tdata[3*CB+7:3*CB];
	assign table_value = s_tdata[3*CB+15:3*CB+8];
	assign operation   = op_t'(s_tuser);

	// Sign extend so the cell byte is always present; floor falls out of
	// two's complement, the fraction is simply the low bits.
	assign ext_x = CX_W'(coord_x);
	assign ext_y = CX_W'(coord_y);
	assign ext_z = CX_W'(coord_z);

	// Global advance: everything moves unless a result is stuck at the output.
	logic           en;
	logic [NST:1]   vld_q;
	logic           accept;

	assign en       = !vld_q[NST] || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = vld_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-1:1], s_tvalid && (operation == OP_EVAL)};
		end
	end

	// Table loads: the write travels with the item stream through the hash.
	perm_wr_t ld;

	always_comb begin
		ld.en  = accept && (operation == OP_LOAD);
		ld.idx = table_index;
		ld.val = table_value;
	end

	logic [7:0] hash [8];

	gnz_hash u_hash (
		.clk(clk), .arst_n(arst_n), .en(en), .ld(ld),
		.cell_x(ext_x[F+7:F]), .cell_y(ext_y[F+7:F]), .cell_z(ext_z[F+7:F]),
		.hash(hash)
	);

	// Fractions, stages 1 to 3 (the hashes arrive at stage 3)
	logic [F-1:0] fx_s1, fy_s1, fz_s1, fx_s2, fy_s2, fz_s2, fx_s3, fy_s3, fz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1 <= ext_x[F-1:0];
			fy_s1 <= ext_y[F-1:0];
			fz_s1 <= ext_z[F-1:0];
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			fz_s2 <= fz_s1;
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fz_s3 <= fz_s2;
		end
	end

	// Fade curves, ready at stage 4
	logic [F:0] fu, fv, fw;

	gnz_fade #(.FRAC_BITS(F)) u_fade_x (.clk(clk), .en(en), .t(fx_s1), .fade(fu));
	gnz_fade #(.FRAC_BITS(F)) u_fade_y (.clk(clk), .en(en), .t(fy_s1), .fade(fv));
	gnz_fade #(.FRAC_BITS(F)) u_fade_z (.clk(clk), .en(en), .t(fz_s1), .fade(fw));

	// Corner offsets t and t - 1, signed Q1.F
	logic signed [F:0] x0, y0, z0, x1, y1, z1;

	assign x0 = $signed({1'b0, fx_s3});
	assign y0 = $signed({1'b0, fy_s3});
	assign z0 = $signed({1'b0, fz_s3});
	assign x1 = x0 - $signed((F+1)'(1) << F);
	assign y1 = y0 - $signed((F+1)'(1) << F);
	assign z1 = z0 - $signed((F+1)'(1) << F);

	function automatic logic signed [GW-1:0] grad_f(
		input logic [7:0]        hv,
		input logic signed [F:0] gx,
		input logic signed [F:0] gy,
		input logic signed [F:0] gz
	);
		logic [3:0]          h;
		logic signed [F:0]   u, v;
		logic signed [GW-1:0] su, sv;
		h = hv[3:0];
		u = (h < GR_SPLIT_U) ? gx : gy;
		if (h < GR_SPLIT_V) begin
			v = gy;
		end else if (h == GR_V_X0 || h == GR_V_X1) begin
			v = gx;
		end else begin
			v = gz;
		end
		su = h[0] ? -GW'(u) : GW'(u);
		sv = h[1] ? -GW'(v) : GW'(v);
		return su + sv;
	endfunction

	// Gradients, stage 4; corner order aa, ba, ab, bb then the z+1 layer
	logic signed [GW-1:0] g_s4 [8];

	always_ff @(posedge clk) begin
		if (en) begin
			g_s4[0] <= grad_f(hash[0], x0, y0, z0);
			g_s4[1] <= grad_f(hash[1], x1, y0, z0);
			g_s4[2] <= grad_f(hash[2], x0, y1, z0);
			g_s4[3] <= grad_f(hash[3], x1, y1, z0);
			g_s4[4] <= grad_f(hash[4], x0, y0, z1);
			g_s4[5] <= grad_f(hash[5], x1, y0, z1);
			g_s4[6] <= grad_f(hash[6], x0, y1, z1);
			g_s4[7] <= grad_f(hash[7], x1, y1, z1);
		end
	end

	// Interpolation, stages 5 to 10
	logic signed [F+1:0] noise_value;

	gnz_interp #(.FRAC_BITS(F)) u_interp (
		.clk(clk), .en(en), .fu(fu), .fv(fv), .fw(fw),
		.grad(g_s4), .noise(noise_value)
	);

	assign m_tdata = OUT_W'(unsigned'(noise_value));

	// A load transfer never puts an item into the result pipeline
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser) |=> !vld_q[1])
		else $error("load produced a pipeline item");

	// An evaluate transfer always enters the result pipeline
	a_eval_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_tuser) |=> vld_q[1])
		else $error("evaluate transfer lost");

	// While stalled the valid bits hold: nothing in flight moves or vanishes
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!en) |=> $stable(vld_q))
		else $error("pipeline moved during stall");

endmodule
